/* rtl/u16u8_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ---------------------------------------------------------------------------
package u16u8_pkg;

  // Surrogate ranges of UTF-16.
  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;

  // Error codes carried with each result beat.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_LONE_LOW   = 2'd1;
  localparam logic [1:0] ERR_BAD_PAIR   = 2'd2;
  localparam logic [1:0] ERR_HIGH_AT_END = 2'd3;

  // UTF-8 lead and continuation markers.
  localparam logic [7:0] LEAD_2 = 8'd192;
  localparam logic [7:0] LEAD_3 = 8'd224;
  localparam logic [7:0] LEAD_4 = 8'd240;
  localparam logic [7:0] CONT   = 8'd128;

  // Bias added to the high surrogate bits: 0x10000 >> 10.
  localparam logic [10:0] SUPP_BIAS = 11'd64;

  // One decoded run of output beats, handed from front to back.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte of the run
    logic [1:0]      err;
    logic            done;
  } cmd_t;

endpackage

/* rtl/u16u8_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u16u8_front
// Classifies code units, pairs surrogates and encodes each scalar into a run.
// ---------------------------------------------------------------------------
module u16u8_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [15:0]       in_code_unit,
  input  logic              in_string_end,
  output logic              cmd_wr,
  output u16u8_pkg::cmd_t   cmd
);
  import u16u8_pkg::*;

  logic        have_high_r, have_high_nxt;
  logic [9:0]  high_bits_r, high_bits_nxt;
  logic        is_high, is_low, emit;
  logic [20:0] pair_scalar;

  function automatic cmd_t encode(input logic [20:0] c, input logic done);
    cmd_t r;
    r = '0;
    r.err = ERR_NONE;
    r.done = done;
    if (c < 21'd128) begin
      r.bytes[0] = c[7:0];
      r.last_idx = 2'd0;
    end else if (c < 21'd2048) begin
      r.bytes[0] = LEAD_2 | {3'd0, c[10:6]};
      r.bytes[1] = CONT | {2'd0, c[5:0]};
      r.last_idx = 2'd1;
    end else if (c < 21'h10000) begin
      r.bytes[0] = LEAD_3 | {4'd0, c[15:12]};
      r.bytes[1] = CONT | {2'd0, c[11:6]};
      r.bytes[2] = CONT | {2'd0, c[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = LEAD_4 | {5'd0, c[20:18]};
      r.bytes[1] = CONT | {2'd0, c[17:12]};
      r.bytes[2] = CONT | {2'd0, c[11:6]};
      r.bytes[3] = CONT | {2'd0, c[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

  assign is_high = in_code_unit inside {[SURR_HI_MIN:SURR_HI_MAX]};
  assign is_low  = in_code_unit inside {[SURR_LO_MIN:SURR_LO_MAX]};
  assign pair_scalar = {({1'b0, high_bits_r} + SUPP_BIAS), in_code_unit[9:0]};

  always_comb begin
    cmd           = '0;
    cmd.done      = in_string_end;
    emit          = 1'b1;
    have_high_nxt = have_high_r;
    high_bits_nxt = high_bits_r;
    if (have_high_r) begin
      have_high_nxt = 1'b0;
      high_bits_nxt = '0;
      if (is_low) begin
        cmd = encode(pair_scalar, in_string_end);
      end else begin
        cmd.err = ERR_BAD_PAIR;
      end
    end else if (is_high) begin
      if (in_string_end) begin
        cmd.err = ERR_HIGH_AT_END;
      end else begin
        emit          = 1'b0;
        have_high_nxt = 1'b1;
        high_bits_nxt = in_code_unit[9:0];
      end
    end else if (is_low) begin
      cmd.err = ERR_LONE_LOW;
    end else begin
      cmd = encode({5'd0, in_code_unit}, in_string_end);
    end
  end

  assign cmd_wr = in_valid && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_high_r <= 1'b0;
      high_bits_r <= '0;
    end else if (in_valid) begin
      have_high_r <= have_high_nxt;
      high_bits_r <= high_bits_nxt;
    end
  end

endmodule

/* rtl/u16u8_cmdq.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u16u8_cmdq
// Small command queue between the front and the back.
// ---------------------------------------------------------------------------
module u16u8_cmdq #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  u16u8_pkg::cmd_t wr_data,
  input  logic            rd,
  output u16u8_pkg::cmd_t rd_data,
  output logic            q_full,
  output logic            q_empty
);
  import u16u8_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == CNT_FULL);
  assign q_empty = (count_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/u16u8_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u16u8_back
// Steps through each queued run and presents one byte per beat.
// ---------------------------------------------------------------------------
module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  u16u8_pkg::cmd_t head,
  input  logic            head_valid,
  output logic            head_take,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic [1:0]      out_error_code,
  output logic            out_string_done
);
  import u16u8_pkg::*;

  logic       out_valid_r;
  logic [1:0] idx_r;
  logic [7:0] byte_r;
  logic       run_last_r, done_r;
  logic [1:0] err_r;
  logic       load, is_last;

  assign load      = head_valid && (!out_valid_r || pop);
  assign is_last   = (idx_r == head.last_idx);
  assign head_take = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= head.bytes[idx_r];
      run_last_r <= is_last;
      err_r      <= head.err;
      done_r     <= is_last && head.done;
    end
  end

  assign empty           = !out_valid_r;
  assign out_byte        = byte_r;
  assign out_run_last    = run_last_r;
  assign out_error_code  = err_r;
  assign out_string_done = done_r;

endmodule

/* rtl/utf16_to_utf8_transcoder_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 code units in, UTF-8 bytes out, one byte per beat.
// ---------------------------------------------------------------------------
// A unit accepted at the input is written into the command queue, and its first
// byte then loads into the output register. The byte emitter gives one output
// byte per cycle while popped; a unit gives 1 to 4, a pending high surrogate none.
// Reset (synchronous, rst_n low) clears the pending surrogate, empties the
// command queue and drops any byte on the output.
module utf16_to_utf8_transcoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_code_unit,
  input  logic        in_string_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic [1:0]  out_error_code,
  output logic        out_string_done
);
  import u16u8_pkg::*;

  // The front decodes each accepted beat straight into the command queue;
  // the back walks the head run one byte at a time into its output register.
  logic push_ok;
  logic q_wr, q_rd, q_full, q_empty;
  cmd_t q_wr_data, q_rd_data;

  // Stall the whole input while the queue is full, even for a high surrogate
  // that would only update the pending state.
  assign full    = q_full;
  assign push_ok = push && !q_full;

  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (push_ok),
    .in_code_unit  (in_code_unit),
    .in_string_end (in_string_end),
    .cmd_wr        (q_wr),
    .cmd           (q_wr_data)
  );

  u16u8_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_rd_data),
    .head_valid      (!q_empty),
    .head_take       (q_rd),
    .pop             (pop),
    .empty           (empty),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_error_code  (out_error_code),
    .out_string_done (out_string_done)
  );

  // An error beat is always a run of its own with a zero byte.
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error_code != ERR_NONE) |-> (out_run_last && out_byte == 8'd0))
    else $error("error beat is not a lone zero byte");

  // The end-of-string flag only rides on the final beat of a run.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_string_done) |-> out_run_last)
    else $error("string_done on a beat that is not the last of its run");

  // A beat that was not popped stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_run_last)))
    else $error("waiting output beat changed");

  // The queue is never both full and empty.
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("command queue full and empty at once");

endmodule
